>>> rtl/core/plsc_pkg.sv
// ----------------------------------------------------------------------------
// plsc_pkg
// Shared types, codes and constants of the palette line scaler.
// ----------------------------------------------------------------------------
package plsc_pkg;

    // Source picture size
    localparam int SRC_W = 160;
    localparam int SRC_H = 144;

    // Default display size
    localparam int DISPLAY_W_DEF = 200;
    localparam int DISPLAY_H_DEF = 228;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS_LEFT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS_TOP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE    = 3'd4;

    // Reset values of the bounds registers
    localparam logic [7:0] BOUNDS_WIDTH_RST  = 8'd200;
    localparam logic [7:0] BOUNDS_HEIGHT_RST = 8'd228;

    // Scale modes; the unused code behaves as stretch
    localparam logic [1:0] SCALE_CENTRED = 2'd0;
    localparam logic [1:0] SCALE_STRETCH = 2'd1;
    localparam logic [1:0] SCALE_FIT     = 2'd2;

    // Item modes; the unused code is dropped
    localparam logic [1:0] MODE_SHADE     = 2'd0;
    localparam logic [1:0] MODE_PALETTE   = 2'd1;
    localparam logic [1:0] MODE_PAL_WRITE = 2'd2;

    // Colour constants
    localparam logic [7:0] OPAQUE = 8'hC0;
    localparam logic [5:0] SHADE_COLOUR [4] = '{6'h3F, 6'h2A, 6'h15, 6'h00};

    // Reciprocals, 16 fractional bits
    localparam logic [15:0] FIT_H_MUL = 16'd58986;  // 144/160
    localparam logic [16:0] FIT_W_MUL = 17'd72820;  // 160/144
    localparam logic [12:0] RECIP9    = 13'd7282;   // 1/9
    localparam logic [13:0] RECIP5    = 14'd13108;  // 1/5

    // Descriptor queue depth
    localparam int QUEUE_DEPTH = 8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  src_col;
        logic [7:0]  src_line;
        logic [5:0]  pixel;
        logic [14:0] palette_word;
    } plsc_in_t;

    typedef struct packed {
        logic [7:0] dest_x;
        logic [7:0] dest_y;
        logic [7:0] argb;
        logic       last;
    } plsc_out_t;

    // Output window in display coordinates
    typedef struct packed {
        logic signed [11:0] ox;
        logic signed [11:0] oy;
        logic [7:0]         ow;
        logic [7:0]         oh;
    } plsc_win_t;

    // Up to two rows by two columns of writes; mask bit 0 is first row,
    // first column, bit 1 first row second column, then the second row
    typedef struct packed {
        logic [7:0] dx0;
        logic [7:0] dy0;
        logic [7:0] argb;
        logic [3:0] mask;
    } plsc_desc_t;

endpackage

>>> rtl/core/palette_line_scaler_unit.sv
// ----------------------------------------------------------------------------
// palette_line_scaler_unit
// Nearest-neighbour scaler of 160x144 source pixels onto a display of 8-bit
// ARGB pixels, with a 64-entry RGB555 palette.
//
// Each source pixel item is mapped into the output window set by the bounds
// registers and the scale mode, and produces zero to four display writes,
// rows outer and columns inner, with last set on the final one. Palette write
// items, line numbers of 144 and up and columns of 160 and up produce no
// writes. An item passes through the front pipeline (palette read with
// products, reciprocal divides, clipping) before its descriptor reaches the
// queue; the front takes a new item every cycle while the queue has room and
// the window has settled. The write sequencer sets the sustained rate; it
// emits one display write per cycle unless the display channel stalls, one
// write per covered pixel of an item. After reset and every configuration
// write the input is held not ready while the window is recomputed.
// ----------------------------------------------------------------------------
module palette_line_scaler_unit #(
    parameter int DISPLAY_W = plsc_pkg::DISPLAY_W_DEF,
    parameter int DISPLAY_H = plsc_pkg::DISPLAY_H_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [plsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [plsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // source item channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  plsc_pkg::plsc_in_t              s_item,
    // display write channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output plsc_pkg::plsc_out_t             m_item
);

    localparam int CNT_W = $clog2(plsc_pkg::QUEUE_DEPTH + 1);

    plsc_pkg::plsc_win_t  win;
    plsc_pkg::plsc_desc_t push_desc, q_head;
    logic                 accept, push, q_pop, q_valid;
    logic [1:0]           inflight;
    logic [CNT_W-1:0]     q_count;
    logic [CNT_W:0]       committed;

    // Window settle time after reset or a register write
    logic [1:0] settle_reg, settle_next;

    always_comb begin
        if (cfg_wr_en) begin
            settle_next = 2'd2;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= 2'd2;
        end else begin
            settle_reg <= settle_next;
        end
    end

    // Hold off when the queue cannot take every item already in the front
    assign committed = (CNT_W+1)'(q_count) + (CNT_W+1)'(inflight);
    assign s_ready   = (settle_reg == 2'd0)
                       && (committed < (CNT_W+1)'(plsc_pkg::QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;

    plsc_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .win       (win)
    );

    plsc_front #(
        .DISPLAY_W (DISPLAY_W),
        .DISPLAY_H (DISPLAY_H)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_item),
        .win       (win),
        .push      (push),
        .push_desc (push_desc),
        .inflight  (inflight)
    );

    plsc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_valid),
        .count     (q_count)
    );

    plsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // A register write must stall the input while the window settles
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input ready while window settles");

endmodule

>>> rtl/core/plsc_window.sv
// ----------------------------------------------------------------------------
// plsc_window
// Configuration registers and the output window derived from them.
// ----------------------------------------------------------------------------
module plsc_window (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [plsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [plsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output plsc_pkg::plsc_win_t             win
);

    logic [8:0] left_reg, top_reg;
    logic [7:0] width_reg, height_reg;
    logic [1:0] scale_reg;

    logic [23:0] fit_h_prod;
    logic [24:0] fit_w_prod;
    logic [7:0]  fit_h_reg, fit_h_next;
    logic [8:0]  fit_w_reg, fit_w_next;

    plsc_pkg::plsc_win_t win_reg, win_next;

    function automatic logic signed [11:0] half_trunc(input logic signed [9:0] v);
        logic signed [9:0] a;
        a = v + ((v < 10'sd0) ? 10'sd1 : 10'sd0);
        return 12'(a >>> 1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= plsc_pkg::BOUNDS_WIDTH_RST;
            height_reg <= plsc_pkg::BOUNDS_HEIGHT_RST;
            scale_reg  <= plsc_pkg::SCALE_CENTRED;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                plsc_pkg::REG_BOUNDS_LEFT:   left_reg   <= cfg_wdata[8:0];
                plsc_pkg::REG_BOUNDS_TOP:    top_reg    <= cfg_wdata[8:0];
                plsc_pkg::REG_BOUNDS_WIDTH:  width_reg  <= cfg_wdata[7:0];
                plsc_pkg::REG_BOUNDS_HEIGHT: height_reg <= cfg_wdata[7:0];
                plsc_pkg::REG_SCALE_MODE:    scale_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Aspect fit candidates: width*144/160 and height*160/144
    always_comb begin
        fit_h_prod = 24'(width_reg) * 24'(plsc_pkg::FIT_H_MUL);
        fit_w_prod = 25'(height_reg) * 25'(plsc_pkg::FIT_W_MUL);
        fit_h_next = fit_h_prod[23:16];
        fit_w_next = fit_w_prod[24:16];
    end

    always_comb begin
        logic signed [11:0] left_s, top_s;
        logic [7:0]         fit_w8;
        left_s = 12'(signed'(left_reg));
        top_s  = 12'(signed'(top_reg));
        fit_w8 = fit_w_reg[7:0];
        win_next.ox = left_s;
        win_next.oy = top_s;
        win_next.ow = width_reg;
        win_next.oh = height_reg;
        priority case (scale_reg)
            plsc_pkg::SCALE_CENTRED: begin
                win_next.ow = 8'(plsc_pkg::SRC_W);
                win_next.oh = 8'(plsc_pkg::SRC_H);
                win_next.ox = left_s + half_trunc(signed'({2'b00, width_reg})
                                                  - 10'sd160);
                win_next.oy = top_s + half_trunc(signed'({2'b00, height_reg})
                                                 - 10'sd144);
            end
            plsc_pkg::SCALE_FIT: begin
                if (fit_h_reg <= height_reg) begin
                    win_next.oh = fit_h_reg;
                    win_next.oy = top_s + 12'(8'(height_reg - fit_h_reg) >> 1);
                end else begin
                    win_next.ow = fit_w8;
                    win_next.ox = left_s + 12'(8'(width_reg - fit_w8) >> 1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        fit_h_reg <= fit_h_next;
        fit_w_reg <= fit_w_next;
        win_reg   <= win_next;
    end

    assign win = win_reg;

endmodule

>>> rtl/core/plsc_front.sv
// ----------------------------------------------------------------------------
// plsc_front
// Accepts items, keeps the palette store, finds the covered rows and columns
// and queues one write descriptor for each source pixel with a visible write.
// ----------------------------------------------------------------------------
module plsc_front #(
    parameter int DISPLAY_W = plsc_pkg::DISPLAY_W_DEF,
    parameter int DISPLAY_H = plsc_pkg::DISPLAY_H_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  plsc_pkg::plsc_in_t      item,
    input  plsc_pkg::plsc_win_t     win,
    output logic                    push,
    output plsc_pkg::plsc_desc_t    push_desc,
    output logic [1:0]              inflight
);

    localparam logic signed [11:0] DISP_W_S = 12'(DISPLAY_W);
    localparam logic signed [11:0] DISP_H_S = 12'(DISPLAY_H);

    // Palette store with per-entry valid bits; an unwritten entry reads zero
    logic [14:0] pal_mem_reg [64];
    logic [63:0] pal_vld_reg;
    logic [14:0] pal_rd_reg;
    logic        pal_ok_reg;

    // Stage 0: accepted draw item
    logic       f0_valid_reg, f0_valid_next;
    logic [1:0] f0_mode_reg;
    logic [7:0] f0_sx_reg, f0_sy_reg;
    logic [1:0] f0_shade_reg;

    // Stage 1: colour and products
    logic        f1_valid_reg;
    logic [7:0]  f1_argb_reg, f1_argb_next;
    logic [15:0] f1_pr0_reg, f1_pr1_reg, f1_pc0_reg, f1_pc1_reg;
    logic [15:0] f1_pr0_next, f1_pr1_next, f1_pc0_next, f1_pc1_next;

    // Stage 2: covered ranges
    logic       f2_valid_reg;
    logic [7:0] f2_argb_reg;
    logic [7:0] f2_r0_reg, f2_r1_reg, f2_c0_reg, f2_c1_reg;

    function automatic logic [7:0] ceil_div144(input logic [15:0] p);
        logic [16:0] s;
        logic [11:0] t;
        logic [24:0] q;
        s = 17'(p) + 17'd143;
        t = 12'(s >> 4);
        q = 25'(t) * 25'(plsc_pkg::RECIP9);
        return q[23:16];
    endfunction

    function automatic logic [7:0] ceil_div160(input logic [15:0] p);
        logic [16:0] s;
        logic [10:0] t;
        logic [24:0] q;
        s = 17'(p) + 17'd159;
        t = 11'(s >> 5);
        q = 25'(t) * 25'(plsc_pkg::RECIP5);
        return q[23:16];
    endfunction

    // Palette write and read
    always_ff @(posedge aclk) begin
        if (accept && item.mode == plsc_pkg::MODE_PAL_WRITE) begin
            pal_mem_reg[item.pixel] <= item.palette_word;
        end
        pal_rd_reg <= pal_mem_reg[item.pixel];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_vld_reg <= '0;
            pal_ok_reg  <= 1'b0;
        end else begin
            pal_ok_reg <= pal_vld_reg[item.pixel];
            if (accept && item.mode == plsc_pkg::MODE_PAL_WRITE) begin
                pal_vld_reg[item.pixel] <= 1'b1;
            end
        end
    end

    // Keep only pixels that can land inside the window
    assign f0_valid_next = accept
        && (item.mode == plsc_pkg::MODE_SHADE || item.mode == plsc_pkg::MODE_PALETTE)
        && (item.src_line < 8'(plsc_pkg::SRC_H))
        && (item.src_col < 8'(plsc_pkg::SRC_W));

    always_ff @(posedge aclk) begin
        if (accept) begin
            f0_mode_reg  <= item.mode;
            f0_sx_reg    <= item.src_col;
            f0_sy_reg    <= item.src_line;
            f0_shade_reg <= item.pixel[1:0];
        end
    end

    always_comb begin
        logic [14:0] c;
        c = pal_ok_reg ? pal_rd_reg : 15'd0;
        if (f0_mode_reg == plsc_pkg::MODE_SHADE) begin
            f1_argb_next = plsc_pkg::OPAQUE | {2'b00, plsc_pkg::SHADE_COLOUR[f0_shade_reg]};
        end else begin
            f1_argb_next = plsc_pkg::OPAQUE | {2'b00, c[14:13], c[9:8], c[4:3]};
        end
        f1_pr0_next = 16'(f0_sy_reg) * 16'(win.oh);
        f1_pr1_next = (16'(f0_sy_reg) + 16'd1) * 16'(win.oh);
        f1_pc0_next = 16'(f0_sx_reg) * 16'(win.ow);
        f1_pc1_next = (16'(f0_sx_reg) + 16'd1) * 16'(win.ow);
    end

    always_ff @(posedge aclk) begin
        f1_argb_reg <= f1_argb_next;
        f1_pr0_reg  <= f1_pr0_next;
        f1_pr1_reg  <= f1_pr1_next;
        f1_pc0_reg  <= f1_pc0_next;
        f1_pc1_reg  <= f1_pc1_next;
        f2_argb_reg <= f1_argb_reg;
        f2_r0_reg   <= ceil_div144(f1_pr0_reg);
        f2_r1_reg   <= ceil_div144(f1_pr1_reg);
        f2_c0_reg   <= ceil_div160(f1_pc0_reg);
        f2_c1_reg   <= ceil_div160(f1_pc1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            f0_valid_reg <= f0_valid_next;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Clip the two candidate rows and columns to the display
    always_comb begin
        logic signed [11:0] dy0, dy1, dx0, dx1;
        logic [7:0]         nrows, ncols;
        logic               row0_ok, row1_ok, col0_ok, col1_ok;
        dy0   = win.oy + signed'({4'b0000, f2_r0_reg});
        dy1   = dy0 + 12'sd1;
        dx0   = win.ox + signed'({4'b0000, f2_c0_reg});
        dx1   = dx0 + 12'sd1;
        nrows = f2_r1_reg - f2_r0_reg;
        ncols = f2_c1_reg - f2_c0_reg;
        row0_ok = (nrows != 8'd0) && (dy0 >= 12'sd0) && (dy0 < DISP_H_S);
        row1_ok = (nrows > 8'd1)  && (dy1 >= 12'sd0) && (dy1 < DISP_H_S);
        col0_ok = (ncols != 8'd0) && (dx0 >= 12'sd0) && (dx0 < DISP_W_S);
        col1_ok = (ncols > 8'd1)  && (dx1 >= 12'sd0) && (dx1 < DISP_W_S);
        push_desc.dx0  = dx0[7:0];
        push_desc.dy0  = dy0[7:0];
        push_desc.argb = f2_argb_reg;
        push_desc.mask = {row1_ok & col1_ok, row1_ok & col0_ok,
                          row0_ok & col1_ok, row0_ok & col0_ok};
        push = f2_valid_reg && (push_desc.mask != 4'd0);
    end

    assign inflight = 2'(f0_valid_reg) + 2'(f1_valid_reg) + 2'(f2_valid_reg);

endmodule

>>> rtl/core/plsc_fifo.sv
// ----------------------------------------------------------------------------
// plsc_fifo
// Short descriptor queue between the front and the write sequencer.
// ----------------------------------------------------------------------------
module plsc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  plsc_pkg::plsc_desc_t push_desc,
    input  logic                 pop,
    output plsc_pkg::plsc_desc_t head,
    output logic                 not_empty,
    output logic [$clog2(plsc_pkg::QUEUE_DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(plsc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(plsc_pkg::QUEUE_DEPTH + 1);

    plsc_pkg::plsc_desc_t slot_reg [plsc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CNT_W'(plsc_pkg::QUEUE_DEPTH)))
        else $error("descriptor queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("descriptor queue underflow");

endmodule

>>> rtl/core/plsc_back.sv
// ----------------------------------------------------------------------------
// plsc_back
// Walks each descriptor and emits one display write per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module plsc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  plsc_pkg::plsc_desc_t q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output plsc_pkg::plsc_out_t  m_item
);

    logic                 cur_valid_reg, cur_valid_next;
    plsc_pkg::plsc_desc_t cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    plsc_pkg::plsc_out_t  out_reg, out_next;

    logic       out_load, emit;
    logic [3:0] pick, rest;
    logic       sel_col, sel_row;

    always_comb begin
        out_load = !out_valid_reg || m_ready;
        emit     = cur_valid_reg && out_load;
        // Lowest set bit gives row-major order
        pick     = cur_reg.mask & (~cur_reg.mask + 4'd1);
        rest     = cur_reg.mask & ~pick;
        sel_col  = pick[1] | pick[3];
        sel_row  = pick[2] | pick[3];

        out_next.dest_x = cur_reg.dx0 + 8'(sel_col);
        out_next.dest_y = cur_reg.dy0 + 8'(sel_row);
        out_next.argb   = cur_reg.argb;
        out_next.last   = (rest == 4'd0);

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        // Advance to the next descriptor once this one is spent
        cur_next      = cur_reg;
        q_pop         = 1'b0;
        if (cur_valid_reg && !(emit && rest == 4'd0)) begin
            cur_valid_next = 1'b1;
            if (emit) begin
                cur_next.mask = rest;
            end
        end else begin
            q_pop          = q_valid;
            cur_valid_next = q_valid;
            cur_next       = q_head;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_live_desc_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_reg.mask != 4'd0))
        else $error("active descriptor with no writes left");

endmodule
